// ----- rtl/checked_data_stack_core_assert.svh -----
// assertion helpers for the checked data stack
`ifndef CHECKED_DATA_STACK_CORE_ASSERT_SVH
`define CHECKED_DATA_STACK_CORE_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CDS_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stack assertion failed");

// next-cycle implication, disabled during reset
`define CDS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stack assertion failed");

`endif

// ----- rtl/cds_pkg.sv -----
`timescale 1ns / 1ps

package cds_pkg;

    // default number of stack entries
    localparam int STACK_DEPTH_DEF = 64;

    // field widths
    localparam int WORD_W  = 64;
    localparam int OP_W    = 3;
    localparam int FAULT_W = 2;
    localparam int DEPTH_W = 7;

    // operation codes
    localparam logic [OP_W-1:0] OP_PUSH  = 3'd0;
    localparam logic [OP_W-1:0] OP_POP   = 3'd1;
    localparam logic [OP_W-1:0] OP_PEEK  = 3'd2;
    localparam logic [OP_W-1:0] OP_SWAP  = 3'd3;
    localparam logic [OP_W-1:0] OP_PAIR  = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR = 3'd5;
    localparam logic [OP_W-1:0] OP_CHECK = 3'd6;

    // fault codes
    localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
    localparam logic [FAULT_W-1:0] FAULT_UNDER = 2'd1;
    localparam logic [FAULT_W-1:0] FAULT_OVER  = 2'd2;

    // cell load select codes
    typedef logic [1:0] t_cell_sel;
    localparam t_cell_sel CELL_HOLD  = 2'd0;
    localparam t_cell_sel CELL_DOWN  = 2'd1;  // take the word from the cell above
    localparam t_cell_sel CELL_UP    = 2'd2;  // take the word from the cell below
    localparam t_cell_sel CELL_CROSS = 2'd3;  // take the swap partner

    // decoded operation from the controller
    typedef struct packed {
        logic                shift_down;
        logic                shift_up;
        logic                swap2;
        logic                swap4;
        logic                read_en;
        logic [FAULT_W-1:0]  fault;
        logic                depth_ok;
    } t_ctrl;

endpackage

// ----- rtl/checked_data_stack_core.sv -----
`timescale 1ns / 1ps
// channel | valid      | ready      | payload
// --------+------------+------------+---------------------------------------------
// input   | i_in_valid | o_in_ready | i_operation, i_push_value, i_required_count
// output  | o_out_valid| i_out_ready| o_read_value, o_fault, o_depth_ok, o_current_depth
//
// one operation per cycle while unstalled; the output register takes its result
// on the input transfer, and the top of stack always sits in the first cell of the chain
// reset clears the depth counter and the output valid; the cells are not cleared
// a stalled output blocks new input only while it is held; taking it frees the slot
// in the same cycle, so back-to-back transfers run at one per cycle

module checked_data_stack_core #(
    parameter int STACK_DEPTH = cds_pkg::STACK_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [cds_pkg::OP_W-1:0]           i_operation,
    input  logic signed [cds_pkg::WORD_W-1:0]  i_push_value,
    input  logic [cds_pkg::DEPTH_W-1:0]        i_required_count,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic signed [cds_pkg::WORD_W-1:0]  o_read_value,
    output logic [cds_pkg::FAULT_W-1:0]        o_fault,
    output logic                               o_depth_ok,
    output logic [cds_pkg::DEPTH_W-1:0]        o_current_depth
);

`include "checked_data_stack_core_assert.svh"

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    logic                             w_fire;
    cds_pkg::t_ctrl                   w_ctrl;
    logic [cds_pkg::DEPTH_W-1:0]      w_depth_next;
    logic [CNT_W-1:0]                 w_count;
    logic [cds_pkg::WORD_W-1:0]       w_cell [STACK_DEPTH];
    cds_pkg::t_cell_sel               w_sel  [STACK_DEPTH];

    logic                             r_out_valid;
    logic [cds_pkg::WORD_W-1:0]       r_read_value;
    logic [cds_pkg::FAULT_W-1:0]      r_fault;
    logic                             r_depth_ok;
    logic [cds_pkg::DEPTH_W-1:0]      r_depth;

    // input transfer when the output slot is free or being drained
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_fire     = i_in_valid && o_in_ready;

    cds_ctrl #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_fire           (w_fire),
        .i_operation      (i_operation),
        .i_required_count (i_required_count),
        .o_ctrl           (w_ctrl),
        .o_depth_next     (w_depth_next),
        .o_count          (w_count)
    );

    // chain of stack cells, top of stack at index 0
    for (genvar gi = 0; gi < STACK_DEPTH; gi++) begin : g_cell
        logic [cds_pkg::WORD_W-1:0] w_above;
        logic [cds_pkg::WORD_W-1:0] w_below;
        logic [cds_pkg::WORD_W-1:0] w_cross;
        logic                       w_cross_en;

        if (gi == 0) begin : g_top
            assign w_above = i_push_value;
        end else begin : g_mid
            assign w_above = w_cell[gi-1];
        end

        if (gi == STACK_DEPTH - 1) begin : g_bot
            assign w_below = w_cell[gi];
        end else begin : g_low
            assign w_below = w_cell[gi+1];
        end

        // swap partners for the top two and the top two pairs
        if (gi == 0) begin : g_x0
            assign w_cross    = w_ctrl.swap2 ? w_cell[1] : w_cell[2];
            assign w_cross_en = w_ctrl.swap2 || w_ctrl.swap4;
        end else if (gi == 1) begin : g_x1
            assign w_cross    = w_ctrl.swap2 ? w_cell[0] : w_cell[3];
            assign w_cross_en = w_ctrl.swap2 || w_ctrl.swap4;
        end else if (gi == 2) begin : g_x2
            assign w_cross    = w_cell[0];
            assign w_cross_en = w_ctrl.swap4;
        end else if (gi == 3) begin : g_x3
            assign w_cross    = w_cell[1];
            assign w_cross_en = w_ctrl.swap4;
        end else begin : g_xn
            assign w_cross    = w_cell[gi];
            assign w_cross_en = 1'b0;
        end

        // per-cell load select
        always_comb begin
            priority if (!w_fire) begin
                w_sel[gi] = cds_pkg::CELL_HOLD;
            end else if (w_ctrl.shift_down) begin
                w_sel[gi] = cds_pkg::CELL_DOWN;
            end else if (w_ctrl.shift_up) begin
                w_sel[gi] = cds_pkg::CELL_UP;
            end else if (w_cross_en) begin
                w_sel[gi] = cds_pkg::CELL_CROSS;
            end else begin
                w_sel[gi] = cds_pkg::CELL_HOLD;
            end
        end

        cds_cell u_cell (
            .i_clk        (i_clk),
            .i_sel        (w_sel[gi]),
            .i_from_above (w_above),
            .i_from_below (w_below),
            .i_cross      (w_cross),
            .o_data       (w_cell[gi])
        );
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_read_value <= w_ctrl.read_en ? w_cell[0] : '0;
            r_fault      <= w_ctrl.fault;
            r_depth_ok   <= w_ctrl.depth_ok;
            r_depth      <= w_depth_next;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_read_value    = r_read_value;
    assign o_fault         = r_fault;
    assign o_depth_ok      = r_depth_ok;
    assign o_current_depth = r_depth;

    // depth never passes the capacity
    `CDS_ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, w_count <= CNT_W'(STACK_DEPTH))
    // an overflow fault is reported only on a full stack
    `CDS_ASSERT_IMPL(a_over_full, i_clk, i_rst_n,
        r_out_valid && (r_fault == cds_pkg::FAULT_OVER), w_count == CNT_W'(STACK_DEPTH))
    // a successful push lands the word at the top cell
    `CDS_ASSERT_NEXT(a_push_top, i_clk, i_rst_n,
        w_fire && (i_operation == cds_pkg::OP_PUSH) && (w_count < CNT_W'(STACK_DEPTH)),
        w_cell[0] == $past(i_push_value))
    // a held result stays valid until taken
    `CDS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && !i_out_ready, r_out_valid)

endmodule

// ----- rtl/cds_cell.sv -----
`timescale 1ns / 1ps

module cds_cell (
    input  logic                      i_clk,
    input  cds_pkg::t_cell_sel        i_sel,
    input  logic [cds_pkg::WORD_W-1:0] i_from_above,
    input  logic [cds_pkg::WORD_W-1:0] i_from_below,
    input  logic [cds_pkg::WORD_W-1:0] i_cross,
    output logic [cds_pkg::WORD_W-1:0] o_data
);

    logic [cds_pkg::WORD_W-1:0] r_data;
    logic [cds_pkg::WORD_W-1:0] n_data;

    // pick the next word for this stack slot
    always_comb begin
        unique case (i_sel)
            cds_pkg::CELL_HOLD:  n_data = r_data;
            cds_pkg::CELL_DOWN:  n_data = i_from_above;
            cds_pkg::CELL_UP:    n_data = i_from_below;
            cds_pkg::CELL_CROSS: n_data = i_cross;
            default:             n_data = r_data;
        endcase
    end

    // payload only, no reset
    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data = r_data;

endmodule

// ----- rtl/cds_ctrl.sv -----
`timescale 1ns / 1ps

module cds_ctrl #(
    parameter int STACK_DEPTH = cds_pkg::STACK_DEPTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_fire,
    input  logic [cds_pkg::OP_W-1:0]      i_operation,
    input  logic [cds_pkg::DEPTH_W-1:0]   i_required_count,
    output cds_pkg::t_ctrl                o_ctrl,
    output logic [cds_pkg::DEPTH_W-1:0]   o_depth_next,
    output logic [$clog2(STACK_DEPTH+1)-1:0] o_count
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int CMP_W = (CNT_W > cds_pkg::DEPTH_W) ? CNT_W : cds_pkg::DEPTH_W;
    localparam logic [CNT_W-1:0] FULL_C = CNT_W'(STACK_DEPTH);
    localparam logic [CNT_W-1:0] ONE_C  = CNT_W'(1);
    localparam logic [CNT_W-1:0] TWO_C  = CNT_W'(2);
    localparam logic [CNT_W-1:0] FOUR_C = CNT_W'(4);

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [CMP_W-1:0] w_count_ext;
    logic [CMP_W-1:0] w_need_ext;
    logic [CMP_W-1:0] w_next_ext;

    assign w_count_ext = CMP_W'(r_count);
    assign w_need_ext  = CMP_W'(i_required_count);

    // decode the operation against the current depth
    always_comb begin
        n_count         = r_count;
        o_ctrl          = '0;
        o_ctrl.fault    = cds_pkg::FAULT_NONE;
        o_ctrl.depth_ok = 1'b1;
        unique case (i_operation)
            cds_pkg::OP_PUSH: begin
                if (r_count < FULL_C) begin
                    o_ctrl.shift_down = 1'b1;
                    n_count           = r_count + ONE_C;
                end else begin
                    o_ctrl.fault    = cds_pkg::FAULT_OVER;
                    o_ctrl.depth_ok = 1'b0;
                end
            end
            cds_pkg::OP_POP, cds_pkg::OP_PEEK: begin
                if (r_count >= ONE_C) begin
                    o_ctrl.read_en = 1'b1;
                    if (i_operation == cds_pkg::OP_POP) begin
                        o_ctrl.shift_up = 1'b1;
                        n_count         = r_count - ONE_C;
                    end
                end else begin
                    o_ctrl.fault    = cds_pkg::FAULT_UNDER;
                    o_ctrl.depth_ok = 1'b0;
                end
            end
            cds_pkg::OP_SWAP: begin
                if (r_count >= TWO_C) begin
                    o_ctrl.swap2 = 1'b1;
                end else begin
                    o_ctrl.fault    = cds_pkg::FAULT_UNDER;
                    o_ctrl.depth_ok = 1'b0;
                end
            end
            cds_pkg::OP_PAIR: begin
                if (r_count >= FOUR_C) begin
                    o_ctrl.swap4 = 1'b1;
                end else begin
                    o_ctrl.fault    = cds_pkg::FAULT_UNDER;
                    o_ctrl.depth_ok = 1'b0;
                end
            end
            cds_pkg::OP_CLEAR: begin
                n_count = '0;
            end
            cds_pkg::OP_CHECK: begin
                if (w_count_ext < w_need_ext) begin
                    o_ctrl.fault    = cds_pkg::FAULT_UNDER;
                    o_ctrl.depth_ok = 1'b0;
                end
            end
            default: begin
                // unused code acts as a no-op
            end
        endcase
    end

    // depth counter, updated on each input transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_fire) begin
            r_count <= n_count;
        end
    end

    assign w_next_ext   = CMP_W'(n_count);
    assign o_depth_next = w_next_ext[cds_pkg::DEPTH_W-1:0];
    assign o_count      = r_count;

endmodule

// ----- verif/stack_result_check.sv -----
`timescale 1ns / 1ps

module stack_result_check #(
    parameter int STACK_DEPTH = cds_pkg::STACK_DEPTH_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    input  logic                               i_in_ready,
    input  logic [cds_pkg::OP_W-1:0]           i_operation,
    input  logic signed [cds_pkg::WORD_W-1:0]  i_push_value,
    input  logic [cds_pkg::DEPTH_W-1:0]        i_required_count,
    input  logic                               i_out_valid,
    input  logic                               i_out_ready,
    input  logic signed [cds_pkg::WORD_W-1:0]  i_read_value,
    input  logic [cds_pkg::FAULT_W-1:0]        i_fault,
    input  logic                               i_depth_ok,
    input  logic [cds_pkg::DEPTH_W-1:0]        i_current_depth,
    output int                                 o_fail_count,
    output int                                 o_pending
);
    import cds_pkg::*;

    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [WORD_W-1:0]  read_value;
        logic [FAULT_W-1:0]        fault;
        logic                      depth_ok;
        logic [DEPTH_W-1:0]        current_depth;
    } stack_result_t;

    // private copy of the stack contents and its fill level
    logic signed [WORD_W-1:0] stack_words [STACK_DEPTH];
    int                       word_count = 0;

    stack_result_t            expected_results [$];
    int                       fail_total = 0;
    int                       results_compared = 0;

    assign o_fail_count = fail_total;

    // count a failure, print only the first few
    function automatic void note_failure(input string msg);
        fail_total++;
        if (fail_total <= REPORT_LIMIT)
            $display("stack check: %s", msg);
    endfunction

    // apply one operation to the private stack and return what the block must report
    function automatic stack_result_t apply_operation(
        input logic [OP_W-1:0]          op,
        input logic signed [WORD_W-1:0] value,
        input logic [DEPTH_W-1:0]       need
    );
        stack_result_t            r;
        logic signed [WORD_W-1:0] held;
        int                       top;
        r.operation  = op;
        r.read_value = '0;
        r.fault      = FAULT_NONE;
        r.depth_ok   = 1'b1;
        top          = word_count - 1;
        case (op)
            OP_PUSH: begin
                if (word_count < STACK_DEPTH) begin
                    stack_words[word_count] = value;
                    word_count++;
                end else begin
                    r.fault    = FAULT_OVER;
                    r.depth_ok = 1'b0;
                end
            end
            OP_POP, OP_PEEK: begin
                if (word_count >= 1) begin
                    r.read_value = stack_words[top];
                    if (op == OP_POP)
                        word_count--;
                end else begin
                    r.fault    = FAULT_UNDER;
                    r.depth_ok = 1'b0;
                end
            end
            OP_SWAP: begin
                if (word_count >= 2) begin
                    held                 = stack_words[top - 1];
                    stack_words[top - 1] = stack_words[top];
                    stack_words[top]     = held;
                end else begin
                    r.fault    = FAULT_UNDER;
                    r.depth_ok = 1'b0;
                end
            end
            OP_PAIR: begin
                if (word_count >= 4) begin
                    held                 = stack_words[top - 2];
                    stack_words[top - 2] = stack_words[top];
                    stack_words[top]     = held;
                    held                 = stack_words[top - 3];
                    stack_words[top - 3] = stack_words[top - 1];
                    stack_words[top - 1] = held;
                end else begin
                    r.fault    = FAULT_UNDER;
                    r.depth_ok = 1'b0;
                end
            end
            OP_CLEAR: begin
                word_count = 0;
            end
            OP_CHECK: begin
                if (word_count < need) begin
                    r.fault    = FAULT_UNDER;
                    r.depth_ok = 1'b0;
                end
            end
            default: begin
            end
        endcase
        r.current_depth = word_count[DEPTH_W-1:0];
        return r;
    endfunction

    // compare result transfers first: a result never belongs to the input of the same edge
    always @(posedge i_clk) begin
        stack_result_t want;
        if (!i_rst_n) begin
            word_count = 0;
            expected_results.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                results_compared++;
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("result %0d arrived with nothing expected",
                                           results_compared));
                end else begin
                    want = expected_results.pop_front();
                    if (i_read_value !== want.read_value || i_fault !== want.fault ||
                        i_depth_ok !== want.depth_ok ||
                        i_current_depth !== want.current_depth)
                        note_failure({
                            $sformatf("result %0d op %0d: expected value %h fault %0d",
                                      results_compared, want.operation, want.read_value,
                                      want.fault),
                            $sformatf(" ok %0d depth %0d, got value %h fault %0d",
                                      want.depth_ok, want.current_depth, i_read_value,
                                      i_fault),
                            $sformatf(" ok %0d depth %0d", i_depth_ok, i_current_depth)});
                end
            end
            if (i_in_valid && i_in_ready)
                expected_results.push_back(
                    apply_operation(i_operation, i_push_value, i_required_count));
        end
        o_pending <= expected_results.size();
    end

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import cds_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
    localparam int RANDOM_PER_PHASE = 350;
    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int DRAIN_CYCLES     = 5;
    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic [1:0] {
        SEG_FILL,
        SEG_DRAIN,
        SEG_MIX
    } seg_kind_t;

    logic clk = 1'b0;
    logic rst_n;

    logic                      in_valid;
    logic                      in_ready;
    logic [OP_W-1:0]           operation;
    logic signed [WORD_W-1:0]  push_value;
    logic [DEPTH_W-1:0]        required_count;
    logic                      out_valid;
    logic                      out_ready;
    logic signed [WORD_W-1:0]  read_value;
    logic [FAULT_W-1:0]        fault;
    logic                      depth_ok;
    logic [DEPTH_W-1:0]        current_depth;

    int fail_count;
    int pending;
    int send_idle_pct;
    int stall_pct;
    int ops_sent;
    int results_seen = 0;
    int overflows_seen = 0;
    int underflows_seen = 0;
    int quiet_cycles = 0;

    // clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    checked_data_stack_core dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_ready       (in_ready),
        .i_operation      (operation),
        .i_push_value     (push_value),
        .i_required_count (required_count),
        .o_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .o_read_value     (read_value),
        .o_fault          (fault),
        .o_depth_ok       (depth_ok),
        .o_current_depth  (current_depth)
    );

    stack_result_check result_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_ready       (in_ready),
        .i_operation      (operation),
        .i_push_value     (push_value),
        .i_required_count (required_count),
        .i_out_valid      (out_valid),
        .i_out_ready      (out_ready),
        .i_read_value     (read_value),
        .i_fault          (fault),
        .i_depth_ok       (depth_ok),
        .i_current_depth  (current_depth),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // result side back-pressure
    always @(posedge clk) begin
        out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // transfer counting and watchdog on cycles with no transfer at all
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            results_seen++;
            if (fault == FAULT_OVER)
                overflows_seen++;
            if (fault == FAULT_UNDER)
                underflows_seen++;
        end
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("stack test: no transfer for %0d cycles", quiet_cycles);
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one operation, with random idle cycles ahead of it, and wait for its transfer
    task automatic send_op(
        input logic [OP_W-1:0]          op,
        input logic signed [WORD_W-1:0] value,
        input logic [DEPTH_W-1:0]       need
    );
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid       <= 1'b0;
            operation      <= OP_W'($urandom);
            push_value     <= {$urandom, $urandom};
            required_count <= DEPTH_W'($urandom);
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        operation      <= op;
        push_value     <= value;
        required_count <= need;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        ops_sent++;
    endtask

    initial begin
        seg_kind_t                seg_kind;
        int                       seg_left;
        int                       pick;
        logic [OP_W-1:0]          op;
        logic signed [WORD_W-1:0] word;

        seg_kind        = SEG_MIX;
        seg_left        = 0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        ops_sent        = 0;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        operation      <= OP_PUSH;
        push_value     <= '0;
        required_count <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: operations on an empty stack, extreme words, reordering, clear
        send_op(OP_POP, '0, '0);
        send_op(OP_PEEK, '0, '0);
        send_op(OP_SWAP, '0, '0);
        send_op(OP_PAIR, '0, '0);
        send_op(OP_CHECK, '0, 7'd0);
        send_op(OP_CHECK, '0, 7'd1);
        send_op(OP_UNUSED, WORD_MAX, 7'd64);
        send_op(OP_PUSH, WORD_MAX, '0);
        send_op(OP_PUSH, WORD_MIN, '0);
        send_op(OP_PUSH, '0, '0);
        send_op(OP_PUSH, -64'sd1, '0);
        send_op(OP_SWAP, '0, '0);
        send_op(OP_PAIR, '0, '0);
        send_op(OP_PEEK, '0, '0);
        send_op(OP_CHECK, '0, 7'd4);
        send_op(OP_CHECK, '0, 7'd5);
        send_op(OP_CHECK, '0, 7'd64);
        send_op(OP_POP, '0, '0);
        send_op(OP_POP, '0, '0);
        send_op(OP_SWAP, '0, '0);
        send_op(OP_CLEAR, '0, '0);
        send_op(OP_PEEK, '0, '0);
        send_op(OP_PUSH, {$urandom, $urandom}, '0);

        // random: fill, drain and mixed stretches under four handshake pressures
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 56; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 56; end
                default: begin send_idle_pct = 28; stall_pct = 28; end
            endcase
            repeat (RANDOM_PER_PHASE) begin
                if (seg_left == 0) begin
                    seg_kind = seg_kind_t'($urandom_range(0, 2));
                    seg_left = $urandom_range(30, 120);
                end
                seg_left--;
                pick = $urandom_range(0, 99);
                case (seg_kind)
                    SEG_FILL:  op = (pick < 70) ? OP_PUSH : (pick < 80) ? OP_POP : OP_UNUSED;
                    SEG_DRAIN: op = (pick < 10) ? OP_PUSH : (pick < 70) ? OP_POP : OP_UNUSED;
                    default:   op = (pick < 35) ? OP_PUSH : (pick < 65) ? OP_POP : OP_UNUSED;
                endcase
                // the remaining share goes to the other operations, clear the rarest
                if (op == OP_UNUSED) begin
                    pick = $urandom_range(0, 19);
                    if (pick == 0)
                        op = OP_CLEAR;
                    else if (pick <= 5)
                        op = OP_PEEK;
                    else if (pick <= 10)
                        op = OP_SWAP;
                    else if (pick <= 15)
                        op = OP_PAIR;
                    else
                        op = OP_CHECK;
                end
                case ($urandom_range(0, 9))
                    0: word = WORD_MAX;
                    1: word = WORD_MIN;
                    2: word = '0;
                    3: word = -64'sd1;
                    default: word = {$urandom, $urandom};
                endcase
                send_op(op, word, DEPTH_W'($urandom_range(0, STACK_DEPTH_DEF)));
            end
        end
        in_valid <= 1'b0;
        stall_pct = 0;

        // let every expected result arrive, then keep watching for strays
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("run covered %0d operations over four handshake pressures, %0d results seen",
                 ops_sent, results_seen);
        $display("faults reported: %0d overflow, %0d underflow, %0d mismatches",
                 overflows_seen, underflows_seen, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
